>>> rtl/aesu_pkg.sv
// shared types and constants for the ascending exchange sort unit
package aesu_pkg;

   localparam int KEY_W = 32;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef struct packed {
      logic inject;
      logic shift;
   } ctl_type;

endpackage

>>> rtl/aesu_cell.sv
// one sorting cell: keeps the smaller key, passes the larger one right, shifts left on drain
module aesu_cell
   import aesu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    shift,
   input  logic    in_valid,
   input  key_type in_key,
   input  logic    nb_valid,
   input  key_type nb_key,
   output logic    out_valid,
   output key_type out_key,
   output logic    held_valid,
   output key_type held_key
);

   logic    held_valid_ff, held_valid_in;
   key_type held_key_ff, held_key_in;
   logic    out_valid_ff, out_valid_in;
   key_type out_key_ff, out_key_in;
   logic    in_smaller;

   assign in_smaller = in_key < held_key_ff;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_key_in   = held_key_ff;
      out_valid_in  = 1'b0;
      out_key_in    = out_key_ff;
      if (shift) begin
         held_valid_in = nb_valid;
         held_key_in   = nb_key;
      end else if (in_valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_key_in   = in_key;
         end else begin
            out_valid_in = 1'b1;
            if (in_smaller) begin
               held_key_in = in_key;
               out_key_in  = held_key_ff;
            end else begin
               out_key_in = in_key;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      held_key_ff <= held_key_in;
      out_key_ff  <= out_key_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_key    = out_key_ff;
   assign held_valid = held_valid_ff;
   assign held_key   = held_key_ff;

endmodule

>>> rtl/aesu_ctrl.sv
// batch sequencer: load, settle and drain phases with key count and overflow flag
module aesu_ctrl
   import aesu_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last_in,
   output logic    req_stall,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output logic    rsp_last_out,
   output logic    rsp_dropped,
   output ctl_type ctl
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [1:0] PH_LOAD   = 2'd0;
   localparam logic [1:0] PH_SETTLE = 2'd1;
   localparam logic [1:0] PH_DRAIN  = 2'd2;

   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] settle_ff, settle_in;
   logic          ovf_ff, ovf_in;
   logic          req_accept, rsp_accept, has_room;

   assign has_room   = count_ff < CW'(DEPTH);
   assign req_stall  = phase_ff != PH_LOAD;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = phase_ff == PH_DRAIN;
   assign rsp_accept = rsp_valid && !rsp_stall;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      settle_in  = settle_ff;
      ovf_in     = ovf_ff;
      ctl.inject = 1'b0;
      ctl.shift  = 1'b0;
      case (phase_ff)
         PH_LOAD: begin
            if (req_accept) begin
               if (has_room) begin
                  ctl.inject = 1'b1;
                  count_in   = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  phase_in  = PH_SETTLE;
                  settle_in = '0;
               end
            end
         end
         PH_SETTLE: begin
            settle_in = settle_ff + CW'(1);
            if (settle_ff == CW'(DEPTH - 1)) begin
               phase_in = PH_DRAIN;
            end
         end
         PH_DRAIN: begin
            if (rsp_accept) begin
               ctl.shift = 1'b1;
               count_in  = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  phase_in = PH_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            phase_in = PH_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LOAD;
         count_ff  <= '0;
         settle_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         settle_ff <= settle_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_last_out = count_ff == CW'(1);
   assign rsp_dropped  = ovf_ff;

endmodule

>>> rtl/ascending_exchange_sort_unit.sv
// top level of the ascending exchange sort unit: cell row and batch sequencer
//
// Keys enter one per cycle into a row of DEPTH cells; each cell keeps the smaller
// of its key and the arriving one and hands the larger to its right neighbor on the
// next cycle. After the transaction marked last, the input stalls through a settle phase
// while the final keys ripple down the row, then the sorted keys leave in ascending
// order from the head cell, one per cycle while rsp_stall is low, the row shifting
// left on each transaction; the input stays stalled until the batch is drained. Keys
// beyond DEPTH are dropped and every result of that batch has rsp_dropped set.
module ascending_exchange_sort_unit
   import aesu_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_key,
   input  logic               req_last_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_sorted_key,
   output logic               rsp_last_out,
   output logic               rsp_dropped
);

   ctl_type ctl;

   logic    carry_valid [0:DEPTH];
   key_type carry_key   [0:DEPTH];
   logic    held_valid  [0:DEPTH];
   key_type held_key    [0:DEPTH];

   aesu_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last_in (req_last_in),
      .req_stall   (req_stall),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_last_out(rsp_last_out),
      .rsp_dropped (rsp_dropped),
      .ctl         (ctl)
   );

   assign carry_valid[0] = ctl.inject;
   assign carry_key[0]   = req_key;
   assign held_valid[DEPTH] = 1'b0;
   assign held_key[DEPTH]   = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      aesu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (ctl.shift),
         .in_valid  (carry_valid[i]),
         .in_key    (carry_key[i]),
         .nb_valid  (held_valid[i+1]),
         .nb_key    (held_key[i+1]),
         .out_valid (carry_valid[i+1]),
         .out_key   (carry_key[i+1]),
         .held_valid(held_valid[i]),
         .held_key  (held_key[i])
      );
   end

   assign rsp_sorted_key = held_key[0];

endmodule
